// ===== hdl/gateway_link_handshake_top_defines.svh =====
// Assertion macros shared by the gateway link handshake RTL.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef GATEWAY_LINK_HANDSHAKE_TOP_DEFINES_SVH
`define GATEWAY_LINK_HANDSHAKE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GLH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("glh assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define GLH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("glh assertion failed");

`endif

// ===== hdl/glh_pkg.sv =====
// Types, codes and constants of the gateway link handshake block.
// Used by the interface instances and every RTL module; no dependencies.
package glh_pkg;

  localparam int unsigned GLH_LIMIT_W   = 14;
  localparam int unsigned DEF_IDLE_WIDTH = 14;
  localparam int unsigned APB_ADDR_W    = 3;
  localparam int unsigned APB_DATA_W    = 32;

  localparam logic [GLH_LIMIT_W-1:0] TIMEOUT_RESET = 14'd10000;

  localparam logic [7:0] TYPE_LOW_ID   = 8'h41;
  localparam logic [7:0] TYPE_HIGH_ID  = 8'h9C;
  localparam logic [7:0] CMD_CONFIG    = 8'h01;
  localparam logic [7:0] CMD_EMPTY     = 8'h00;
  localparam logic [7:0] CMD_DONE      = 8'h80;
  localparam logic [7:0] CMD_DATA      = 8'h02;
  localparam logic [7:0] ANNOUNCE_BYTE = 8'h01;

  // Register index, taken from paddr bit 2.
  localparam logic REG_TIMEOUT_LIMIT = 1'b0;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_ANNOUNCE = 2'd1,
    KIND_CONFIG   = 2'd2,
    KIND_DATA     = 2'd3
  } glh_kind_e;

  typedef struct packed {
    logic       action;
    logic [7:0] type_low;
    logic [7:0] type_high;
    logic [7:0] master_counter;
    logic [7:0] cmd_high;
    logic [7:0] cmd_low;
    logic       mem_ok;
  } glh_in_t;

  typedef struct packed {
    glh_kind_e  send_kind;
    logic [7:0] ack_value;
    logic [7:0] counter_value;
    logic       configured;
    logic       link_lost;
  } glh_out_t;

endpackage

// ===== hdl/glh_stream_if.sv =====
// Valid/ready channel carrying one item of a given payload type.
// Instantiated with the payload structs of glh_pkg.
interface glh_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/gateway_link_handshake_top.sv =====
// Top level of the gateway link handshake slave.
// Depends on glh_pkg, glh_stream_if, glh_apb_regs, glh_in_reg and glh_step.

// The block takes one item per clock cycle and returns exactly one result per item:
// the item is captured in an input register, decided by combinational compare and
// increment logic, and held in a result register until the sink takes it. Both
// registers advance together, so the sustained rate is one item per cycle as long as
// the result side keeps taking. The timeout limit is written over the APB port at byte
// address 0 (reset value 10000) and is read back there.
module gateway_link_handshake_top
  import glh_pkg::*;
#(
  parameter int unsigned IDLE_WIDTH = DEF_IDLE_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  glh_stream_if.sink            in_i,
  glh_stream_if.source          out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [GLH_LIMIT_W-1:0] limit;
  logic                   s1_valid;
  glh_in_t                s1_item;
  logic                   s1_adv;

  glh_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit_o (limit)
  );

  glh_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .adv_i   (s1_adv),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  glh_step #(
    .IDLE_WIDTH (IDLE_WIDTH)
  ) u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .item_i  (s1_item),
    .limit_i (limit),
    .adv_o   (s1_adv),
    .out_o   (out_o)
  );

endmodule

// ===== hdl/glh_apb_regs.sv =====
// APB configuration register holding the idle timeout limit.
// Depends on glh_pkg.
module glh_apb_regs
  import glh_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [APB_ADDR_W-1:0]      paddr,
  input  logic [APB_DATA_W-1:0]      pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready,
  output logic [GLH_LIMIT_W-1:0]     limit_o
);

  logic                   wr_en;
  logic [GLH_LIMIT_W-1:0] limit_q, limit_d;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    limit_d = limit_q;
    prdata  = '0;
    unique case (paddr[2])
      REG_TIMEOUT_LIMIT: begin
        prdata = APB_DATA_W'(limit_q);
        if (wr_en) begin
          limit_d = pwdata[GLH_LIMIT_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= TIMEOUT_RESET;
    end else begin
      limit_q <= limit_d;
    end
  end

  assign limit_o = limit_q;

endmodule

// ===== hdl/glh_in_reg.sv =====
// Input register stage: captures one header or tick item per cycle while the decision stage takes its items.
// Depends on glh_pkg and glh_stream_if.
module glh_in_reg
  import glh_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  glh_stream_if.sink   in_i,
  input  logic         adv_i,
  output logic         valid_o,
  output glh_in_t      item_o
);

  logic    valid_q, valid_d;
  glh_in_t item_q;

  // The stage frees up whenever the decision stage takes its item.
  assign in_i.ready = !valid_q || adv_i;

  always_comb begin
    valid_d = valid_q;
    if (in_i.ready) begin
      valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= in_i.payload;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== hdl/glh_step.sv =====
// Link state and per-item decision, followed by the result register.
// Depends on glh_pkg, glh_stream_if and the assertion macro header.
`include "gateway_link_handshake_top_defines.svh"

module glh_step
  import glh_pkg::*;
#(
  parameter int unsigned IDLE_WIDTH = DEF_IDLE_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  glh_in_t                item_i,
  input  logic [GLH_LIMIT_W-1:0] limit_i,
  output logic                   adv_o,
  glh_stream_if.source           out_o
);

  localparam int unsigned CmpW = (IDLE_WIDTH > GLH_LIMIT_W) ? IDLE_WIDTH : GLH_LIMIT_W;

  logic                  in_exch_q, in_exch_d;
  logic                  answered_q, answered_d;
  logic [7:0]            gate_q, gate_d;
  logic [7:0]            data_q, data_d;
  logic [IDLE_WIDTH-1:0] idle_q, idle_d;
  logic                  out_valid_q, out_valid_d;
  glh_out_t              out_q, res;

  logic                  take;
  logic [7:0]            gate_base;
  logic                  hdr_match;
  logic [IDLE_WIDTH-1:0] idle_next;
  logic                  dropped;

  assign adv_o = !out_valid_q || out_o.ready;
  assign take  = valid_i && adv_o;

  assign gate_base = answered_q ? gate_q : 8'd1;
  assign hdr_match = (item_i.type_low == TYPE_LOW_ID) && (item_i.type_high == TYPE_HIGH_ID)
                     && (item_i.cmd_high == CMD_CONFIG);
  assign idle_next = item_i.action ? '0
                   : ((idle_q == '1) ? idle_q : idle_q + IDLE_WIDTH'(1));

  always_comb begin
    in_exch_d  = in_exch_q;
    answered_d = answered_q;
    gate_d     = gate_q;
    data_d     = data_q;
    idle_d     = idle_q;
    dropped    = 1'b0;
    res        = '{send_kind: KIND_NONE, ack_value: 8'd0, counter_value: 8'd0,
                   configured: 1'b0, link_lost: 1'b0};
    if (!in_exch_q) begin
      gate_d = gate_base;
      if (!item_i.action) begin
        if (!answered_q) begin
          res.send_kind     = KIND_ANNOUNCE;
          res.ack_value     = ANNOUNCE_BYTE;
          res.counter_value = ANNOUNCE_BYTE;
        end
      end else if (hdr_match) begin
        if ((item_i.cmd_low == CMD_EMPTY) && !answered_q) begin
          answered_d        = 1'b1;
          gate_d            = gate_base + 8'd1;
          res.send_kind     = KIND_CONFIG;
          res.ack_value     = item_i.master_counter;
          res.counter_value = gate_base + 8'd1;
        end else if (item_i.cmd_low == CMD_DONE) begin
          data_d            = gate_base + 8'd1;
          res.send_kind     = KIND_DATA;
          res.ack_value     = item_i.master_counter;
          res.counter_value = gate_base + 8'd1;
          if (item_i.mem_ok) begin
            in_exch_d = 1'b1;
          end else begin
            answered_d    = 1'b0;
            res.link_lost = 1'b1;
          end
        end
      end
    end else begin
      if (item_i.action && (item_i.cmd_high == CMD_DATA)) begin
        data_d            = data_q + 8'd1;
        res.send_kind     = KIND_DATA;
        res.ack_value     = item_i.master_counter;
        res.counter_value = data_q + 8'd1;
        if (!item_i.mem_ok) begin
          dropped = 1'b1;
        end
      end
      // The timeout only counts while the link is still up after this item.
      if (!dropped && (CmpW'(idle_next) >= CmpW'(limit_i))) begin
        dropped = 1'b1;
      end
      idle_d = dropped ? '0 : idle_next;
      if (dropped) begin
        answered_d    = 1'b0;
        in_exch_d     = 1'b0;
        res.link_lost = 1'b1;
      end
    end
    res.configured = in_exch_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv_o) begin
      out_valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_exch_q   <= 1'b0;
      answered_q  <= 1'b0;
      gate_q      <= 8'd0;
      data_q      <= 8'd0;
      idle_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        in_exch_q  <= in_exch_d;
        answered_q <= answered_d;
        gate_q     <= gate_d;
        data_q     <= data_d;
        idle_q     <= idle_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= res;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  `GLH_ASSERT_NOW(a_idle_zero_in_config, !in_exch_q, idle_q == '0)
  `GLH_ASSERT_NOW(a_lost_not_configured, out_valid_q && out_q.link_lost, !out_q.configured)
  `GLH_ASSERT_NOW(a_announce_bytes, out_valid_q && (out_q.send_kind == KIND_ANNOUNCE),
                  (out_q.ack_value == ANNOUNCE_BYTE) && !out_q.configured)
  `GLH_ASSERT_NEXT(a_take_gives_result, take, out_valid_q)

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for the gateway link handshake slave: directed and random items against a
// built-in prediction of the link state. Depends on glh_pkg, glh_stream_if and the RTL.
module tb_top;
  import glh_pkg::*;

  localparam int unsigned IDLE_W = DEF_IDLE_WIDTH;
  localparam int unsigned WATCHDOG_CYCLES = 2000;
  localparam int unsigned REPORT_MAX = 10;
  localparam logic [APB_ADDR_W-1:0] ADDR_TIMEOUT_LIMIT =
    APB_ADDR_W'({REG_TIMEOUT_LIMIT, 2'b00});

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  glh_stream_if #(.payload_t(glh_in_t))  in_if ();
  glh_stream_if #(.payload_t(glh_out_t)) out_if ();

  gateway_link_handshake_top u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted link state, advanced once per accepted item.
  logic                   link_in_exchange = 1'b0;
  logic                   link_answered    = 1'b0;
  logic [7:0]             gate_count       = 8'd0;
  logic [7:0]             data_count       = 8'd0;
  logic [IDLE_W-1:0]      idle_count       = '0;
  logic [GLH_LIMIT_W-1:0] timeout_limit_q  = TIMEOUT_RESET;

  glh_out_t    pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  logic        idle_enable    = 1'b1;
  int unsigned mem_fail_odds  = 19;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  task automatic check_field(string name, int unsigned expv, int unsigned actv);
    if (expv != actv) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
        $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h", $time, name, expv, actv);
    end
  endtask

  function automatic glh_out_t predict_link_step(glh_in_t it);
    glh_out_t r;
    r = '0;
    r.send_kind = KIND_NONE;
    if (!link_in_exchange) begin
      // Every configuration item restarts the gate count until the master is answered.
      if (!link_answered) gate_count = 8'd1;
      if (!it.action) begin
        if (!link_answered) begin
          r.send_kind     = KIND_ANNOUNCE;
          r.ack_value     = ANNOUNCE_BYTE;
          r.counter_value = ANNOUNCE_BYTE;
        end
      end else if (it.type_low == TYPE_LOW_ID && it.type_high == TYPE_HIGH_ID &&
                   it.cmd_high == CMD_CONFIG) begin
        if (it.cmd_low == CMD_EMPTY && !link_answered) begin
          link_answered   = 1'b1;
          gate_count      = gate_count + 8'd1;
          r.send_kind     = KIND_CONFIG;
          r.ack_value     = it.master_counter;
          r.counter_value = gate_count;
        end else if (it.cmd_low == CMD_DONE) begin
          link_in_exchange = it.mem_ok;
          if (!it.mem_ok) begin
            link_answered = 1'b0;
            r.link_lost   = 1'b1;
          end
          data_count      = gate_count + 8'd1;
          r.send_kind     = KIND_DATA;
          r.ack_value     = it.master_counter;
          r.counter_value = data_count;
        end
      end
    end else begin
      if (it.action) begin
        idle_count = '0;
        if (it.cmd_high == CMD_DATA) begin
          if (!it.mem_ok) begin
            link_answered    = 1'b0;
            link_in_exchange = 1'b0;
            r.link_lost      = 1'b1;
          end
          data_count      = data_count + 8'd1;
          r.send_kind     = KIND_DATA;
          r.ack_value     = it.master_counter;
          r.counter_value = data_count;
        end
      end else if (idle_count != '1) begin
        idle_count = idle_count + 1'b1;
      end
      if (link_in_exchange && idle_count >= timeout_limit_q) begin
        link_answered    = 1'b0;
        link_in_exchange = 1'b0;
        idle_count       = '0;
        r.link_lost      = 1'b1;
      end
    end
    r.configured = link_in_exchange;
    return r;
  endfunction

  function automatic glh_in_t link_tick(logic mem);
    glh_in_t it;
    it = '0;
    it.mem_ok = mem;
    return it;
  endfunction

  function automatic glh_in_t link_packet(logic [7:0] chi, logic [7:0] clo,
                                          logic [7:0] mctr, logic mem);
    glh_in_t it;
    it.action         = 1'b1;
    it.type_low       = TYPE_LOW_ID;
    it.type_high      = TYPE_HIGH_ID;
    it.master_counter = mctr;
    it.cmd_high       = chi;
    it.cmd_low        = clo;
    it.mem_ok         = mem;
    return it;
  endfunction

  // Mostly well-formed traffic for the current link phase, with some noise and
  // corrupted headers mixed in.
  function automatic glh_in_t next_link_item();
    glh_in_t     it;
    int unsigned pick;
    logic        mem;
    logic [7:0]  flip;
    pick = $urandom_range(0, 99);
    mem  = ($urandom_range(0, mem_fail_odds) != 0);
    flip = 8'($urandom_range(1, 255));
    if (pick < 10) begin
      it.action         = 1'($urandom);
      it.type_low       = 8'($urandom);
      it.type_high      = 8'($urandom);
      it.master_counter = 8'($urandom);
      it.cmd_high       = 8'($urandom);
      it.cmd_low        = 8'($urandom);
      it.mem_ok         = 1'($urandom);
    end else if (!link_in_exchange) begin
      if (pick < (link_answered ? 25 : 35))
        it = link_tick(mem);
      else if (pick < (link_answered ? 45 : 70))
        it = link_packet(CMD_CONFIG, CMD_EMPTY, 8'($urandom), mem);
      else
        it = link_packet(CMD_CONFIG, CMD_DONE, 8'($urandom), mem);
      if (it.action && $urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0:       it.type_low  ^= flip;
          1:       it.type_high ^= flip;
          2:       it.cmd_high  ^= flip;
          default: it.cmd_low   ^= flip;
        endcase
      end
    end else begin
      if (pick < 55)
        it = link_packet(CMD_DATA, 8'($urandom), 8'($urandom), mem);
      else if (pick < 88)
        it = link_tick(mem);
      else
        it = link_packet(8'($urandom), 8'($urandom), 8'($urandom), mem);
    end
    return it;
  endfunction

  task automatic send_link_item(glh_in_t it);
    if (idle_enable && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk_i); while (!in_if.ready);
    pending_results.push_back(predict_link_step(it));
  endtask

  task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read(logic [APB_ADDR_W-1:0] addr, output logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // The limit only changes once the block has drained and settled.
  task automatic set_timeout_limit(logic [GLH_LIMIT_W-1:0] limit);
    logic [APB_DATA_W-1:0] rd;
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    apb_write(ADDR_TIMEOUT_LIMIT, APB_DATA_W'(limit));
    timeout_limit_q = limit;
    apb_read(ADDR_TIMEOUT_LIMIT, rd);
    check_field("timeout_limit readback", limit, rd);
  endtask

  task automatic test_reset_value();
    logic [APB_DATA_W-1:0] rd;
    apb_read(ADDR_TIMEOUT_LIMIT, rd);
    check_field("timeout_limit after reset", TIMEOUT_RESET, rd);
  endtask

  task automatic test_config_handshake();
    glh_in_t it;
    send_link_item(link_tick(1'b1));
    it = link_packet(CMD_CONFIG, CMD_EMPTY, 8'h11, 1'b1);
    it.type_low = 8'h00;
    send_link_item(it);
    it = link_packet(CMD_CONFIG, CMD_EMPTY, 8'h22, 1'b1);
    it.type_high = 8'hFF;
    send_link_item(it);
    send_link_item(link_packet(8'hFF, CMD_EMPTY, 8'h33, 1'b1));
    send_link_item(link_packet(CMD_CONFIG, CMD_EMPTY, 8'hFF, 1'b1));
    // A second empty packet after the answer is ignored, as is a tick.
    send_link_item(link_packet(CMD_CONFIG, CMD_EMPTY, 8'h44, 1'b1));
    send_link_item(link_tick(1'b0));
    send_link_item(link_packet(CMD_CONFIG, CMD_DONE, 8'h00, 1'b0));
    // Entering the exchange without a prior answer is allowed.
    send_link_item(link_packet(CMD_CONFIG, CMD_DONE, 8'h5A, 1'b1));
    send_link_item(link_packet(CMD_DATA, 8'hFF, 8'hFF, 1'b1));
    send_link_item(link_packet(8'hFF, 8'hFF, 8'h00, 1'b1));
    it = link_packet(CMD_DATA, 8'h00, 8'hA5, 1'b1);
    it.type_low  = 8'hFF;
    it.type_high = 8'h00;
    send_link_item(it);
    send_link_item(link_packet(CMD_DATA, 8'h7E, 8'h81, 1'b0));
  endtask

  task automatic test_idle_timeout();
    set_timeout_limit(GLH_LIMIT_W'(1));
    send_link_item(link_packet(CMD_CONFIG, CMD_DONE, 8'h01, 1'b1));
    send_link_item(link_tick(1'b1));
    set_timeout_limit(GLH_LIMIT_W'(3));
    send_link_item(link_packet(CMD_CONFIG, CMD_DONE, 8'h02, 1'b1));
    send_link_item(link_tick(1'b1));
    send_link_item(link_tick(1'b1));
    send_link_item(link_packet(CMD_DATA, 8'h00, 8'hFF, 1'b1));
    repeat (3) send_link_item(link_tick(1'b1));
    set_timeout_limit('1);
    send_link_item(link_packet(CMD_CONFIG, CMD_DONE, 8'h03, 1'b1));
    repeat (2) send_link_item(link_tick(1'b0));
  endtask

  task automatic test_random_traffic();
    int unsigned count;
    for (int phase = 0; phase < 8; phase++) begin
      count = 60;
      mem_fail_odds = 19;
      if (phase == 7) idle_enable = 1'b0;
      case (phase % 4)
        0: set_timeout_limit(GLH_LIMIT_W'(1));
        1: begin
          // A long run without drops lets the data counter wrap around.
          set_timeout_limit('1);
          count = (phase == 1) ? 560 : 60;
          mem_fail_odds = 100000;
        end
        2: set_timeout_limit(GLH_LIMIT_W'($urandom_range(2, 8)));
        default: set_timeout_limit(GLH_LIMIT_W'($urandom_range(9, 64)));
      endcase
      repeat (count) send_link_item(next_link_item());
    end
  endtask

  // Result side stalls in random bursts while idling is enabled.
  initial begin
    out_if.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (idle_enable && $urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    glh_out_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("%0t result with no item pending: 0x%0h", $time, out_if.payload);
      end else begin
        want = pending_results.pop_front();
        check_field("send_kind", want.send_kind, out_if.payload.send_kind);
        check_field("ack_value", want.ack_value, out_if.payload.ack_value);
        check_field("counter_value", want.counter_value, out_if.payload.counter_value);
        check_field("configured", want.configured, out_if.payload.configured);
        check_field("link_lost", want.link_lost, out_if.payload.link_lost);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.payload <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_value();
    test_config_handshake();
    test_idle_timeout();
    test_random_traffic();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
